### rtl/core/njf_pkg.sv
// Shared types and constants for the net junction finder.
package njf_pkg;

   localparam int DEF_MAX_SEGMENTS = 16;
   localparam int DEF_MAX_POINTS = 64;
   localparam int COORD_W = 32;
   localparam int CNT_W = 8;
   localparam int KIND_W = 2;

   localparam logic [KIND_W-1:0] KIND_OPEN = 2'd0;
   localparam logic [KIND_W-1:0] KIND_JUNCTION = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

   localparam logic CMD_SEGMENT = 1'b0;
   localparam logic CMD_PIN = 1'b1;

   typedef struct packed {
      logic valid;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } pt_type;

   typedef struct packed {
      logic valid;
      logic [COORD_W-1:0] ax;
      logic [COORD_W-1:0] ay;
      logic [COORD_W-1:0] bx;
      logic [COORD_W-1:0] by;
   } seg_type;

   typedef struct packed {
      logic active;
      logic count_mode;
      logic found;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [CNT_W-1:0] cnt;
   } tok_type;

endpackage

### rtl/core/njf_point_cell.sv
// One stored point of the chain: load shift, pick search and count update.
module njf_point_cell (
   input  logic clock,
   input  logic reset,
   input  logic shift1,
   input  logic shift2,
   input  logic clear,
   input  njf_pkg::pt_type src1,
   input  njf_pkg::pt_type src2,
   output njf_pkg::pt_type ent,
   input  njf_pkg::tok_type tok_in,
   output njf_pkg::tok_type tok_out
);
   import njf_pkg::*;

   pt_type  ent_ff;
   logic    done_ff;
   tok_type tok_ff;
   tok_type tok_in_n;
   logic    hit;

   always_comb begin
      tok_in_n = tok_in;
      hit = 1'b0;
      if (tok_in.active) begin
         if (!tok_in.count_mode) begin
            if (ent_ff.valid && !done_ff &&
                (!tok_in.found || ($signed(ent_ff.y) <= $signed(tok_in.y)))) begin
               tok_in_n.found = 1'b1;
               tok_in_n.x = ent_ff.x;
               tok_in_n.y = ent_ff.y;
            end
         end else if (ent_ff.valid && ent_ff.x == tok_in.x && ent_ff.y == tok_in.y) begin
            hit = 1'b1;
            tok_in_n.cnt = tok_in.cnt + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff <= '0;
         done_ff <= 1'b0;
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_n;
         if (clear) begin
            ent_ff.valid <= 1'b0;
            done_ff <= 1'b0;
         end else if (shift2) begin
            ent_ff <= src2;
            done_ff <= 1'b0;
         end else if (shift1) begin
            ent_ff <= src1;
            done_ff <= 1'b0;
         end else if (hit) begin
            done_ff <= 1'b1;
         end
      end
   end

   assign ent = ent_ff;
   assign tok_out = tok_ff;
endmodule

### rtl/core/njf_seg_cell.sv
// One stored segment of the chain: load shift and strict-interior test.
module njf_seg_cell (
   input  logic clock,
   input  logic reset,
   input  logic shift,
   input  logic clear,
   input  njf_pkg::seg_type src,
   output njf_pkg::seg_type ent,
   input  njf_pkg::tok_type tok_in,
   output njf_pkg::tok_type tok_out
);
   import njf_pkg::*;

   seg_type ent_ff;
   tok_type tok_ff;
   tok_type tok_in_n;
   logic    vert;
   logic    horiz;
   logic    in_y;
   logic    in_x;

   always_comb begin
      vert = ent_ff.ax == ent_ff.bx;
      horiz = ent_ff.ay == ent_ff.by;
      in_y = ($signed(ent_ff.ay) < $signed(tok_in.y) && $signed(tok_in.y) < $signed(ent_ff.by))
          || ($signed(ent_ff.by) < $signed(tok_in.y) && $signed(tok_in.y) < $signed(ent_ff.ay));
      in_x = ($signed(ent_ff.ax) < $signed(tok_in.x) && $signed(tok_in.x) < $signed(ent_ff.bx))
          || ($signed(ent_ff.bx) < $signed(tok_in.x) && $signed(tok_in.x) < $signed(ent_ff.ax));
      tok_in_n = tok_in;
      if (tok_in.active && tok_in.count_mode && ent_ff.valid) begin
         if (vert) begin
            if (ent_ff.ax == tok_in.x && in_y) begin
               tok_in_n.cnt = tok_in.cnt + CNT_W'(2);
            end
         end else if (horiz && ent_ff.ay == tok_in.y && in_x) begin
            tok_in_n.cnt = tok_in.cnt + CNT_W'(2);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff <= '0;
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_n;
         if (clear) begin
            ent_ff.valid <= 1'b0;
         end else if (shift) begin
            ent_ff <= src;
         end
      end
   end

   assign ent = ent_ff;
   assign tok_out = tok_ff;
endmodule

### rtl/core/net_junction_finder.sv
// Top level of the net junction finder: cell chains and run sequencer.
//
// Input stream: one wire segment (tuser = 0) or pin (tuser = 1) per
// transaction, one per cycle while loading. tlast marks the last item of a
// run; it is loaded and then classification starts.
// Classification sends a search token down the chain of point cells and
// segment cells, one cell per cycle. Each distinct point takes two trips:
// one to pick the lowest unvisited y, one to count coincident points and
// segment interiors. A final pick trip finds nothing, and the final state
// closes the run; each found result passes through the emit state.
// req_tready is low from the last item until the final result is taken
// into the output register.
// Output stream: unconnected ends and junctions in ascending y, tlast on
// the final one; an empty marker (kind 2) when nothing is found. The output
// register holds while rsp_tready is low and classification waits on it.
// Items that do not fit are dropped and flagged in every result of the run.
// Reset empties all stores; the block is ready the cycle after reset.
module net_junction_finder #(
   parameter int MAX_SEGMENTS = njf_pkg::DEF_MAX_SEGMENTS,
   parameter int MAX_POINTS = njf_pkg::DEF_MAX_POINTS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [127:0] req_tdata,  // ax, ay, bx, by
   input  logic req_tuser,          // command
   input  logic req_tlast,          // final_req
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [63:0] rsp_tdata,   // px, py
   output logic [2:0] rsp_tuser,    // kind, dropped
   output logic rsp_tlast           // run_end
);
   import njf_pkg::*;

   localparam int SC_W = $clog2(MAX_SEGMENTS + 1);
   localparam int PC_W = $clog2(MAX_POINTS + 1);

   typedef enum logic [2:0] {S_IDLE, S_PICK, S_COUNT, S_EMIT, S_FINAL} state_type;

   state_type state_ff;
   logic [SC_W-1:0] seg_count_ff;
   logic [PC_W-1:0] point_count_ff;
   logic ovf_ff;
   logic launch_ff;
   logic mode_ff;
   logic [COORD_W-1:0] cx_ff, cy_ff;
   logic [KIND_W-1:0] kind_ff;
   logic pend_valid_ff;
   logic [COORD_W-1:0] pend_x_ff, pend_y_ff;
   logic [KIND_W-1:0] pend_kind_ff;
   logic out_valid_ff;
   logic [COORD_W-1:0] out_x_ff, out_y_ff;
   logic [KIND_W-1:0] out_kind_ff;
   logic out_drop_ff, out_last_ff;

   logic accept, is_seg, seg_fit, pin_fit, shift1, shift2, seg_shift, clear, out_free;
   logic launch_in, out_load;
   pt_type new_a, new_b;
   seg_type new_seg;
   tok_type head, tail;
   pt_type  pent [MAX_POINTS];
   tok_type ptok [MAX_POINTS];
   seg_type sent [MAX_SEGMENTS];
   tok_type stok [MAX_SEGMENTS];

   assign req_tready = state_ff == S_IDLE;
   assign accept = req_tvalid && req_tready;
   assign is_seg = req_tuser == CMD_SEGMENT;
   assign seg_fit = (seg_count_ff < SC_W'(MAX_SEGMENTS))
                 && (point_count_ff <= PC_W'(MAX_POINTS - 2));
   assign pin_fit = point_count_ff < PC_W'(MAX_POINTS);
   assign shift2 = accept && is_seg && seg_fit;
   assign shift1 = accept && !is_seg && pin_fit;
   assign seg_shift = shift2;
   assign out_free = !out_valid_ff || rsp_tready;
   assign clear = state_ff == S_FINAL && out_free;

   assign new_a = '{valid: 1'b1, x: req_tdata[31:0], y: req_tdata[63:32]};
   assign new_b = '{valid: 1'b1, x: req_tdata[95:64], y: req_tdata[127:96]};
   assign new_seg = '{valid: 1'b1, ax: req_tdata[31:0], ay: req_tdata[63:32],
                      bx: req_tdata[95:64], by: req_tdata[127:96]};

   always_comb begin
      head = '0;
      head.active = launch_ff;
      head.count_mode = mode_ff;
      head.x = cx_ff;
      head.y = cy_ff;
   end

   genvar gi;
   generate
      for (gi = 0; gi < MAX_POINTS; gi++) begin : g_pt
         pt_type s1, s2;
         tok_type ti;
         if (gi == 0) begin : g_first
            assign s1 = new_a;
            assign s2 = new_b;
            assign ti = head;
         end else if (gi == 1) begin : g_second
            assign s1 = pent[0];
            assign s2 = new_a;
            assign ti = ptok[0];
         end else begin : g_rest
            assign s1 = pent[gi-1];
            assign s2 = pent[gi-2];
            assign ti = ptok[gi-1];
         end
         njf_point_cell u_cell (
            .clock(clock), .reset(reset), .shift1(shift1), .shift2(shift2),
            .clear(clear), .src1(s1), .src2(s2), .ent(pent[gi]),
            .tok_in(ti), .tok_out(ptok[gi])
         );
      end
      for (gi = 0; gi < MAX_SEGMENTS; gi++) begin : g_seg
         seg_type sr;
         tok_type ti;
         if (gi == 0) begin : g_first
            assign sr = new_seg;
            assign ti = ptok[MAX_POINTS-1];
         end else begin : g_rest
            assign sr = sent[gi-1];
            assign ti = stok[gi-1];
         end
         njf_seg_cell u_cell (
            .clock(clock), .reset(reset), .shift(seg_shift), .clear(clear),
            .src(sr), .ent(sent[gi]), .tok_in(ti), .tok_out(stok[gi])
         );
      end
   endgenerate

   assign tail = stok[MAX_SEGMENTS-1];

   assign launch_in = (state_ff == S_IDLE && accept && req_tlast)
                   || (state_ff == S_PICK && tail.active && tail.found)
                   || (state_ff == S_COUNT && tail.active && tail.cnt == CNT_W'(2))
                   || (state_ff == S_EMIT && (!pend_valid_ff || out_free));
   assign out_load = (state_ff == S_EMIT && pend_valid_ff && out_free)
                  || (state_ff == S_FINAL && out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         seg_count_ff <= '0;
         point_count_ff <= '0;
         ovf_ff <= 1'b0;
         launch_ff <= 1'b0;
         mode_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         launch_ff <= launch_in;
         if (out_valid_ff && rsp_tready && !out_load) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (shift2) begin
                     seg_count_ff <= seg_count_ff + SC_W'(1);
                     point_count_ff <= point_count_ff + PC_W'(2);
                  end else if (shift1) begin
                     point_count_ff <= point_count_ff + PC_W'(1);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (req_tlast) begin
                     mode_ff <= 1'b0;
                     state_ff <= S_PICK;
                  end
               end
            end
            S_PICK: begin
               if (tail.active) begin
                  if (tail.found) begin
                     cx_ff <= tail.x;
                     cy_ff <= tail.y;
                     mode_ff <= 1'b1;
                     state_ff <= S_COUNT;
                  end else begin
                     state_ff <= S_FINAL;
                  end
               end
            end
            S_COUNT: begin
               if (tail.active) begin
                  if (tail.cnt == CNT_W'(2)) begin
                     mode_ff <= 1'b0;
                     state_ff <= S_PICK;
                  end else begin
                     kind_ff <= (tail.cnt < CNT_W'(2)) ? KIND_OPEN : KIND_JUNCTION;
                     state_ff <= S_EMIT;
                  end
               end
            end
            S_EMIT: begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     out_valid_ff <= 1'b1;
                     out_x_ff <= pend_x_ff;
                     out_y_ff <= pend_y_ff;
                     out_kind_ff <= pend_kind_ff;
                     out_drop_ff <= ovf_ff;
                     out_last_ff <= 1'b0;
                  end
                  pend_valid_ff <= 1'b1;
                  pend_x_ff <= cx_ff;
                  pend_y_ff <= cy_ff;
                  pend_kind_ff <= kind_ff;
                  mode_ff <= 1'b0;
                  state_ff <= S_PICK;
               end
            end
            S_FINAL: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_drop_ff <= ovf_ff;
                  out_last_ff <= 1'b1;
                  if (pend_valid_ff) begin
                     out_x_ff <= pend_x_ff;
                     out_y_ff <= pend_y_ff;
                     out_kind_ff <= pend_kind_ff;
                  end else begin
                     out_x_ff <= '0;
                     out_y_ff <= '0;
                     out_kind_ff <= KIND_NONE;
                  end
                  pend_valid_ff <= 1'b0;
                  seg_count_ff <= '0;
                  point_count_ff <= '0;
                  ovf_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {out_y_ff, out_x_ff};
   assign rsp_tuser = {out_drop_ff, out_kind_ff};
   assign rsp_tlast = out_last_ff;
endmodule

### rtl/core/njf_checker.sv
// Port-level checks for the net junction finder, bound to the top level.
module njf_port_assertions (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [2:0] rsp_tuser,
   input logic rsp_tlast
);
   import njf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[1:0] == KIND_OPEN || rsp_tuser[1:0] == KIND_JUNCTION
                      || rsp_tuser[1:0] == KIND_NONE))
      else $error("illegal kind");

   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_NONE |-> rsp_tdata == '0 && rsp_tlast)
      else $error("bad empty marker");

   a_busy_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input open in middle of run");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result after reset");
endmodule

bind net_junction_finder njf_port_assertions u_njf_port_assertions (
   .clock(clock), .reset(reset), .req_tready(req_tready), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
   .rsp_tlast(rsp_tlast)
);
